/* rtl/acst_pkg.sv */
// shared widths, defaults and fixed-point limits for the affine composition tree
package acst_pkg;

  localparam int SLOT_W = 17;
  localparam int GAIN_W = 32;
  localparam int OFFS_W = 49;

  localparam int DEF_LEAVES    = 131072;
  localparam int DEF_FRAC_BITS = 30;

  // saturation limit for every offset and for value_at_one
  localparam logic signed [OFFS_W-1:0] OFFS_MAX = {1'b0, {(OFFS_W-1){1'b1}}};

  // stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = ((SLOT_W + 2 * GAIN_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((GAIN_W + 4 * OFFS_W + 7) / 8) * 8;

endpackage

/* rtl/affine_composition_segment_tree.sv */
// affine map composition tree: leaf update, path recompute to root, running min and max
//
//  channel | dir | handshake        | tdata fields (lowest bit first)
//  --------+-----+------------------+-----------------------------------------------------
//  s_      | in  | s_tvalid/s_tready| slot_index[16:0], leaf_gain[48:17], leaf_offset[80:49]
//  m_      | out | m_tvalid/m_tready| root_gain[31:0], root_offset[80:32],
//          |     |                  | value_at_one[129:81], running_min[178:130],
//          |     |                  | running_max[227:179]
//
// steps: an in-range slot walks from its leaf up to the root; each tree level is one
//   memory read of the sibling with the write-back of the current node, a step of
//   three registered multiplies, a step of add and saturate. an out-of-range slot
//   takes the root read only.
// reset: a clearing pass writes the identity map into every node, with s_tready low
//   until it ends.
// stalls: one transaction is worked at a time; the result sits in an output register,
//   so the next transaction is taken while it waits, and the final step holds only
//   if the previous result has not yet left.
module affine_composition_segment_tree #(
  parameter int LEAVES    = acst_pkg::DEF_LEAVES,
  parameter int FRAC_BITS = acst_pkg::DEF_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // slot_index, leaf_gain, leaf_offset, zero pad
  input  logic [acst_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // root_gain, root_offset, value_at_one, running_min, running_max, zero pad
  output logic [acst_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int GW     = acst_pkg::GAIN_W;
  localparam int OW     = acst_pkg::OFFS_W;
  localparam int SW     = acst_pkg::SLOT_W;
  localparam int LEAF_AW = (LEAVES > 1) ? $clog2(LEAVES) : 1;
  localparam int AW     = LEAF_AW + 1;          // node address, root at 1
  localparam int HI_W   = OW - FRAC_BITS;       // integer part of an offset
  localparam int PH_W   = GW + HI_W;
  localparam int PL_W   = GW + FRAC_BITS + 1;
  localparam int SUM_W  = OW + 3;
  localparam int WORD_W = GW + OW;

  localparam logic signed [GW-1:0]    ONE_G = GW'(64'(1) << FRAC_BITS);
  localparam logic signed [GW-1:0]    NEG_ONE_G = -ONE_G;
  localparam logic signed [OW-1:0]    ONE_O = OW'(64'(1) << FRAC_BITS);
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(acst_pkg::OFFS_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX;
  localparam logic [AW-1:0]           ROOT_ADDR = AW'(1);
  localparam logic [AW-1:0]           PAD_BASE  = AW'(64'(1) << LEAF_AW);

  // sequencer codes
  localparam logic [2:0] ST_CLEAR     = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_LVL_RD    = 3'd2;
  localparam logic [2:0] ST_LVL_MUL   = 3'd3;
  localparam logic [2:0] ST_LVL_ADD   = 3'd4;
  localparam logic [2:0] ST_ROOT_RD   = 3'd5;
  localparam logic [2:0] ST_ROOT_WAIT = 3'd6;
  localparam logic [2:0] ST_FINISH    = 3'd7;

  // saturate a wide sum into the offset range
  function automatic logic signed [OW-1:0] sat_offs(input logic signed [SUM_W-1:0] v);
    logic signed [OW-1:0] r;
    if (v > SUM_MAX) r = acst_pkg::OFFS_MAX;
    else if (v < SUM_MIN) r = -acst_pkg::OFFS_MAX;
    else r = OW'(v);
    return r;
  endfunction

  // node memory: {offset, gain} per node
  logic [WORD_W-1:0] node_mem [2**AW];
  logic [WORD_W-1:0] mem_rdata;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic              mem_we;

  logic [2:0]        state;
  logic [AW-1:0]     clear_addr;
  logic [AW-1:0]     node_k;

  // node being carried up the path
  logic signed [GW-1:0] cur_gain;
  logic signed [OW-1:0] cur_offset;

  // registered products of one level
  logic signed [2*GW-1:0] prod_gain;
  logic signed [PH_W-1:0] prod_hi;
  logic signed [PL_W-1:0] prod_lo;
  logic signed [OW-1:0]   right_offset;

  logic signed [OW-1:0] min_seen;
  logic signed [OW-1:0] max_seen;

  // output register fields
  logic signed [GW-1:0] out_gain;
  logic signed [OW-1:0] out_offset;
  logic signed [OW-1:0] out_value;
  logic signed [OW-1:0] out_min;
  logic signed [OW-1:0] out_max;

  // input decode
  logic [SW-1:0]        in_slot;
  logic signed [GW-1:0] in_gain_raw;
  logic signed [GW-1:0] in_offs_raw;
  logic signed [GW-1:0] in_gain;
  logic signed [GW-1:0] in_offs;
  logic                 in_range;
  logic                 in_fire;

  // level operand selection
  logic                    cur_is_left;
  logic signed [GW-1:0]    sib_gain;
  logic signed [OW-1:0]    sib_offset;
  logic signed [GW-1:0]    gain_l;
  logic signed [GW-1:0]    gain_r;
  logic signed [OW-1:0]    offs_l;
  logic signed [OW-1:0]    offs_r;
  logic signed [HI_W-1:0]  offs_l_hi;
  logic signed [FRAC_BITS:0] offs_l_lo;

  // root evaluation
  logic signed [SUM_W-1:0] level_sum;
  logic signed [SUM_W-1:0] value_sum;
  logic signed [OW-1:0]    value_sat;
  logic signed [OW-1:0]    min_next;
  logic signed [OW-1:0]    max_next;
  logic                    out_free;

  assign in_slot     = s_tdata[SW-1:0];
  assign in_gain_raw = signed'(s_tdata[SW+GW-1:SW]);
  assign in_offs_raw = signed'(s_tdata[SW+2*GW-1:SW+GW]);

  // saturate leaf values to [-1, 1]
  always_comb begin
    if (in_gain_raw > ONE_G) in_gain = ONE_G;
    else if (in_gain_raw < NEG_ONE_G) in_gain = NEG_ONE_G;
    else in_gain = in_gain_raw;
    if (in_offs_raw > ONE_G) in_offs = ONE_G;
    else if (in_offs_raw < NEG_ONE_G) in_offs = NEG_ONE_G;
    else in_offs = in_offs_raw;
  end

  assign in_range = (64'(in_slot) < 64'(LEAVES));
  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // sibling fields from the memory read
  assign sib_gain    = signed'(mem_rdata[GW-1:0]);
  assign sib_offset  = signed'(mem_rdata[WORD_W-1:GW]);
  assign cur_is_left = !node_k[0];

  always_comb begin
    if (cur_is_left) begin
      gain_l = cur_gain;
      offs_l = cur_offset;
      gain_r = sib_gain;
      offs_r = sib_offset;
    end else begin
      gain_l = sib_gain;
      offs_l = sib_offset;
      gain_r = cur_gain;
      offs_r = cur_offset;
    end
    // floor split of the left offset into integer and fraction
    offs_l_hi = signed'(offs_l[OW-1:FRAC_BITS]);
    offs_l_lo = signed'({1'b0, offs_l[FRAC_BITS-1:0]});
  end

  // parent offset: gr * ol with floor, plus right offset
  assign level_sum = SUM_W'(prod_hi) + SUM_W'(prod_lo >>> FRAC_BITS)
                   + SUM_W'(right_offset);

  // composite at t = 1 and the running extremes
  assign value_sum = SUM_W'(cur_gain) + SUM_W'(cur_offset);
  assign value_sat = sat_offs(value_sum);
  assign min_next  = (value_sat < min_seen) ? value_sat : min_seen;
  assign max_next  = (value_sat > max_seen) ? value_sat : max_seen;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = node_k;
    mem_wdata = {cur_offset, cur_gain};
    mem_raddr = node_k ^ ROOT_ADDR;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clear_addr;
        mem_wdata = {OW'(0), ONE_G};
      end
      ST_LVL_RD: begin
        mem_we = 1'b1;
      end
      ST_ROOT_RD: begin
        mem_raddr = ROOT_ADDR;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) node_mem[mem_waddr] <= mem_wdata;
    mem_rdata <= node_mem[mem_raddr];
  end

  // sequencer and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      node_k     <= '0;
      m_tvalid   <= 1'b0;
      min_seen   <= acst_pkg::OFFS_MAX;
      max_seen   <= ONE_O;
    end else begin
      // a new result takes precedence over the drain of the old one
      if (state == ST_FINISH && out_free) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clear_addr <= clear_addr + AW'(1);
          if (clear_addr == '1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_fire) begin
            if (in_range) begin
              node_k <= PAD_BASE | AW'(in_slot);
              state  <= ST_LVL_RD;
            end else begin
              state <= ST_ROOT_RD;
            end
          end
        end
        ST_LVL_RD: begin
          // current node written back; root reached when the address is one
          if (node_k == ROOT_ADDR) state <= ST_FINISH;
          else state <= ST_LVL_MUL;
        end
        ST_LVL_MUL: begin
          state <= ST_LVL_ADD;
        end
        ST_LVL_ADD: begin
          node_k <= node_k >> 1;
          state  <= ST_LVL_RD;
        end
        ST_ROOT_RD: begin
          state <= ST_ROOT_WAIT;
        end
        ST_ROOT_WAIT: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            min_seen <= min_next;
            max_seen <= max_next;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_fire) begin
      cur_gain   <= in_gain;
      cur_offset <= OW'(in_offs);
    end
    if (state == ST_LVL_MUL) begin
      prod_gain    <= gain_l * gain_r;
      prod_hi      <= gain_r * offs_l_hi;
      prod_lo      <= gain_r * offs_l_lo;
      right_offset <= offs_r;
    end
    if (state == ST_LVL_ADD) begin
      cur_gain   <= GW'(prod_gain >>> FRAC_BITS);
      cur_offset <= sat_offs(level_sum);
    end
    if (state == ST_ROOT_WAIT) begin
      cur_gain   <= sib_gain;
      cur_offset <= sib_offset;
    end
    if (state == ST_FINISH && out_free) begin
      out_gain   <= cur_gain;
      out_offset <= cur_offset;
      out_value  <= value_sat;
      out_min    <= min_next;
      out_max    <= max_next;
    end
  end

  assign m_tdata = {(acst_pkg::OUT_DATA_W - GW - 4 * OW)'(0),
                    out_max, out_min, out_value, out_offset, out_gain};

  // an in-range transaction always starts its walk at the leaf level
  a_leaf_start: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_range) |=> (state == ST_LVL_RD && node_k[AW-1]))
    else $error("walk did not start at a leaf");

  // the walk's current node never becomes the unused node zero
  a_node_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LVL_RD || state == ST_LVL_MUL || state == ST_LVL_ADD) |-> (node_k != '0))
    else $error("tree walk reached node zero");

  // composite gain stays within [-1, 1]
  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_gain <= ONE_G && out_gain >= NEG_ONE_G))
    else $error("root gain out of range");

  // once a result exists the extremes bracket its value
  a_min_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_min <= out_value && out_value <= out_max))
    else $error("running extremes do not bracket value");

endmodule
